// ----- rtl/core/mbps_pkg.sv -----
// Package for the masked byte pattern scanner.
// Holds shared constants, request codes, register indexes and the beat control type.
// No dependencies.
package mbps_pkg;

    localparam int DEF_MAX_PATTERN = 64;
    localparam int DEF_OFFSET_BITS = 32;

    localparam int PAT_IDX_W  = 6;
    localparam int PAT_LEN_W  = 7;
    localparam int OFS_OUT_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Request type codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_IMAGE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HINT_ENABLE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HINT_OFFSET    = 2'd2;

    localparam logic [PAT_LEN_W-1:0] PAT_LEN_RESET = 7'd1;

    // Control of the image beat held in the input register.
    typedef struct packed {
        logic valid;
        logic last;
    } beat_ctl_t;

endpackage

// ----- rtl/core/mbps_req_if.sv -----
// Request channel of the masked byte pattern scanner: pattern loads and image bytes.
// Depends on mbps_pkg.
interface mbps_req_if;
    import mbps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [PAT_IDX_W-1:0] pat_index;
    logic [7:0]           pat_byte;
    logic                 pat_care;
    logic [7:0]           data_byte;
    logic                 last_byte;

    modport source (
        output valid, req_type, pat_index, pat_byte, pat_care, data_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, pat_index, pat_byte, pat_care, data_byte, last_byte,
        output ready
    );
endinterface

// ----- rtl/core/mbps_res_if.sv -----
// Result channel of the masked byte pattern scanner.
// Depends on mbps_pkg.
interface mbps_res_if;
    import mbps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [OFS_OUT_W-1:0] match_offset;
    logic                 from_hint;

    modport source (
        output valid, found, match_offset, from_hint,
        input  ready
    );
    modport sink (
        input  valid, found, match_offset, from_hint,
        output ready
    );
endinterface

// ----- rtl/core/mbps_cfg_if.sv -----
// Configuration write channel of the masked byte pattern scanner.
// Depends on mbps_pkg.
interface mbps_cfg_if;
    import mbps_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- rtl/core/mbps_scan_front.sv -----
// Input side of the scanner: pattern store, byte window, scan counters and input register.
// Depends on mbps_pkg and mbps_req_if.
module mbps_scan_front #(
    parameter int MAX_PATTERN = mbps_pkg::DEF_MAX_PATTERN,
    parameter int OFFSET_BITS = mbps_pkg::DEF_OFFSET_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    mbps_req_if.sink                           req,
    input  logic                               retire,
    output mbps_pkg::beat_ctl_t                beat,
    output logic [OFFSET_BITS-1:0]             beat_ofs,
    output logic [$clog2(MAX_PATTERN+1)-1:0]   beat_fill,
    output logic [MAX_PATTERN*8-1:0]           win_flat,
    output logic [MAX_PATTERN*8-1:0]           pat_flat,
    output logic [MAX_PATTERN-1:0]             care_vec
);
    import mbps_pkg::*;

    localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
    localparam int IDX_CMP_W = (LEN_W > PAT_IDX_W) ? LEN_W : PAT_IDX_W;

    logic [7:0]             pat_reg [MAX_PATTERN];
    logic                   care_reg [MAX_PATTERN];
    logic [7:0]             win_reg [MAX_PATTERN];
    logic [LEN_W-1:0]       fill_reg, fill_next, fill_inc;
    logic [OFFSET_BITS-1:0] seen_reg, seen_next;
    beat_ctl_t              beat_reg, beat_next;
    logic [OFFSET_BITS-1:0] beat_ofs_reg;
    logic [LEN_W-1:0]       beat_fill_reg;
    logic                   accept, img_acc, load_acc;

    assign req.ready = !beat_reg.valid || retire;
    assign accept    = req.valid && req.ready;
    assign img_acc   = accept && (req.req_type == REQ_IMAGE);
    assign load_acc  = accept && (req.req_type == REQ_LOAD);

    // The fill count saturates at the window depth.
    assign fill_inc = (fill_reg == LEN_W'(MAX_PATTERN)) ? fill_reg : fill_reg + LEN_W'(1);

    always_comb
    begin
        fill_next = fill_reg;
        seen_next = seen_reg;
        beat_next = beat_reg;
        if (retire)
        begin
            beat_next.valid = 1'b0;
        end
        if (img_acc)
        begin
            beat_next.valid = 1'b1;
            beat_next.last  = req.last_byte;
            fill_next       = req.last_byte ? '0 : fill_inc;
            seen_next       = req.last_byte ? '0 : seen_reg + OFFSET_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            seen_reg <= '0;
            beat_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            seen_reg <= seen_next;
            beat_reg <= beat_next;
        end
    end

    // Payload storage. Window bytes outside the current fill are never compared.
    always_ff @(posedge clk)
    begin
        if (img_acc)
        begin
            beat_ofs_reg  <= seen_reg;
            beat_fill_reg <= fill_inc;
            win_reg[0]    <= req.data_byte;
            for (int k = 1; k < MAX_PATTERN; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (load_acc && (IDX_CMP_W'(req.pat_index) == IDX_CMP_W'(k)))
            begin
                pat_reg[k]  <= req.pat_byte;
                care_reg[k] <= req.pat_care;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            win_flat[k*8 +: 8] = win_reg[k];
            pat_flat[k*8 +: 8] = pat_reg[k];
            care_vec[k]        = care_reg[k];
        end
    end

    assign beat      = beat_reg;
    assign beat_ofs  = beat_ofs_reg;
    assign beat_fill = beat_fill_reg;

endmodule

// ----- rtl/core/mbps_match.sv -----
// Parallel wildcard compare of the byte window against the active pattern positions.
// Depends on mbps_pkg.
module mbps_match #(
    parameter int MAX_PATTERN = mbps_pkg::DEF_MAX_PATTERN
) (
    input  logic [MAX_PATTERN*8-1:0]         win_flat,
    input  logic [MAX_PATTERN*8-1:0]         pat_flat,
    input  logic [MAX_PATTERN-1:0]           care_vec,
    input  logic [$clog2(MAX_PATTERN+1)-1:0] len,
    input  logic [$clog2(MAX_PATTERN+1)-1:0] fill,
    output logic                             hit
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [MAX_PATTERN*8-1:0] rev_win;
    logic [MAX_PATTERN*8-1:0] aligned;
    logic [LEN_W-1:0]         shift_bytes;
    logic [MAX_PATTERN-1:0]   miss;

    // Pattern position i lines up with the byte len-1-i places back, which is
    // byte MAX_PATTERN-len+i of the reversed window.
    assign shift_bytes = LEN_W'(MAX_PATTERN) - len;
    assign aligned     = rev_win >> {shift_bytes, 3'b000};

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            rev_win[k*8 +: 8] = win_flat[(MAX_PATTERN-1-k)*8 +: 8];
            miss[k] = (LEN_W'(k) < len) && care_vec[k]
                      && (pat_flat[k*8 +: 8] != aligned[k*8 +: 8]);
        end
    end

    assign hit = (fill >= len) && !(|miss);

endmodule

// ----- rtl/core/masked_byte_pattern_scanner_unit.sv -----
// Top level of the masked byte pattern scanner: configuration, hit tracking, result register.
// Depends on mbps_pkg, the three channel interfaces, mbps_scan_front and mbps_match.
//
// Usage. Pattern positions are loaded over the req channel with req_type = 0
// (pat_index, pat_byte, pat_care; a clear care bit makes a wildcard). Image
// bytes follow with req_type = 1, one per beat, and the beat with last_byte = 1
// ends the scan. That beat alone yields one beat on the res channel: found,
// the start offset of the first match (or of the hinted match when hint_enable
// is set and a match starts at hint_offset, then from_hint = 1), zero if none.
// Registers pattern_length, hint_enable and hint_offset are written on the cfg
// channel, which is always ready; write them only while no scan is under way.
// Throughput is one beat per cycle while req.ready is high. An image byte is
// held in the input register while the window compare runs, and the result
// of a scan is then registered for res. The result register lets the
// next scan stream in while a result waits; req.ready drops only when a second
// last beat must retire and the earlier result has not been taken. Reset
// clears the scan state and sets pattern_length to one; the pattern store is
// not cleared and must be loaded before use. After each result the window,
// offset counter and hit state restart for the next scan, keeping the pattern.
module masked_byte_pattern_scanner_unit #(
    parameter int MAX_PATTERN = mbps_pkg::DEF_MAX_PATTERN,
    parameter int OFFSET_BITS = mbps_pkg::DEF_OFFSET_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    mbps_req_if.sink   req,
    mbps_cfg_if.sink   cfg,
    mbps_res_if.source res
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W = (LEN_W > PAT_LEN_W) ? LEN_W : PAT_LEN_W;

    // Configuration registers.
    logic [PAT_LEN_W-1:0]  pat_len_reg;
    logic                  hint_en_reg;
    logic [OFS_OUT_W-1:0]  hint_ofs_reg;

    // Scan front outputs.
    beat_ctl_t                beat;
    logic [OFFSET_BITS-1:0]   beat_ofs;
    logic [LEN_W-1:0]         beat_fill;
    logic [MAX_PATTERN*8-1:0] win_flat;
    logic [MAX_PATTERN*8-1:0] pat_flat;
    logic [MAX_PATTERN-1:0]   care_vec;
    logic                     hit;
    logic                     retire;

    // Hit tracking.
    logic                   fhv_reg, fhv_next;
    logic [OFFSET_BITS-1:0] fho_reg, fho_next;
    logic                   hh_reg, hh_next;
    logic                   fhv_eff, hh_eff;
    logic [OFFSET_BITS-1:0] fho_eff;
    logic [OFFSET_BITS-1:0] start_ofs;
    logic [OFFSET_BITS-1:0] hint_cmp;
    logic [CMP_W-1:0]       len_ext;
    logic [LEN_W-1:0]       len;

    // Result register.
    logic                   res_valid_reg, res_valid_next;
    logic                   found_reg;
    logic [OFS_OUT_W-1:0]   match_ofs_reg;
    logic                   from_hint_reg;

    // Configuration writes; an index beyond the list is dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg  <= PAT_LEN_RESET;
            hint_en_reg  <= 1'b0;
            hint_ofs_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_PATTERN_LENGTH: pat_len_reg  <= cfg.data[PAT_LEN_W-1:0];
                CFG_HINT_ENABLE:    hint_en_reg  <= cfg.data[0];
                CFG_HINT_OFFSET:    hint_ofs_reg <= cfg.data[OFS_OUT_W-1:0];
                default:            ;
            endcase
        end
    end

    // A length of zero acts as one, and a length beyond the window acts as the
    // full window.
    assign len_ext = CMP_W'(pat_len_reg);

    always_comb
    begin
        if (len_ext == '0)
        begin
            len = LEN_W'(1);
        end
        else if (len_ext > CMP_W'(MAX_PATTERN))
        begin
            len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len = LEN_W'(len_ext);
        end
    end

    mbps_scan_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .retire    (retire),
        .beat      (beat),
        .beat_ofs  (beat_ofs),
        .beat_fill (beat_fill),
        .win_flat  (win_flat),
        .pat_flat  (pat_flat),
        .care_vec  (care_vec)
    );

    mbps_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .win_flat (win_flat),
        .pat_flat (pat_flat),
        .care_vec (care_vec),
        .len      (len),
        .fill     (beat_fill),
        .hit      (hit)
    );

    // The held beat leaves unless it is a last beat and the result register is
    // still occupied by an untaken result.
    assign retire = beat.valid && (!beat.last || !res_valid_reg || res.ready);

    // The match ends at the current byte, so it starts len-1 bytes earlier.
    assign start_ofs = beat_ofs - OFFSET_BITS'(len) + OFFSET_BITS'(1);
    assign hint_cmp  = OFFSET_BITS'(hint_ofs_reg);

    assign fhv_eff = fhv_reg || hit;
    assign fho_eff = fhv_reg ? fho_reg : start_ofs;
    assign hh_eff  = hh_reg || (hit && hint_en_reg && (start_ofs == hint_cmp));

    always_comb
    begin
        fhv_next       = fhv_reg;
        fho_next       = fho_reg;
        hh_next        = hh_reg;
        res_valid_next = res_valid_reg && !res.ready;
        if (retire)
        begin
            if (beat.last)
            begin
                fhv_next       = 1'b0;
                fho_next       = '0;
                hh_next        = 1'b0;
                res_valid_next = 1'b1;
            end
            else
            begin
                fhv_next = fhv_eff;
                fho_next = fho_eff;
                hh_next  = hh_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fhv_reg       <= 1'b0;
            fho_reg       <= '0;
            hh_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            fhv_reg       <= fhv_next;
            fho_reg       <= fho_next;
            hh_reg        <= hh_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload: the hinted match wins over the first one.
    always_ff @(posedge clk)
    begin
        if (retire && beat.last)
        begin
            if (hh_eff)
            begin
                found_reg     <= 1'b1;
                match_ofs_reg <= OFS_OUT_W'(hint_cmp);
                from_hint_reg <= 1'b1;
            end
            else if (fhv_eff)
            begin
                found_reg     <= 1'b1;
                match_ofs_reg <= OFS_OUT_W'(fho_eff);
                from_hint_reg <= 1'b0;
            end
            else
            begin
                found_reg     <= 1'b0;
                match_ofs_reg <= '0;
                from_hint_reg <= 1'b0;
            end
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.found        = found_reg;
    assign res.match_offset = match_ofs_reg;
    assign res.from_hint    = from_hint_reg;

`ifndef SYNTHESIS
    a_hint_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && from_hint_reg |-> found_reg)
        else $error("hinted result without a match");

    a_none_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !found_reg |-> match_ofs_reg == '0)
        else $error("empty result carries a nonzero offset");

    a_hint_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && from_hint_reg |-> hint_en_reg)
        else $error("hinted result while hint checking is off");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(retire && beat.last))
        else $error("result raised without a retiring last beat");
`endif

endmodule
